// ----- rtl/stt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the source text tokenizer.
package stt_pkg;

	localparam int CNT_W   = 24;
	localparam int OUT_W   = 24;
	localparam int VAL_W   = 31;
	localparam int NAME_W  = 40;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_END  = 1'b1;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;

	// names packed first character in the low byte
	localparam logic [NAME_W-1:0] KW_PRINT = "tnirp";
	localparam logic [NAME_W-1:0] KW_IF    = {24'd0, "fi"};
	localparam logic [NAME_W-1:0] KW_ELSE  = {8'd0, "esle"};

	typedef enum logic [2:0] {
		SM_IDLE    = 3'd0,
		SM_COMMENT = 3'd1,
		SM_STRING  = 3'd2,
		SM_NUMBER  = 3'd3,
		SM_IDENT   = 3'd4,
		SM_LT      = 3'd5,
		SM_GT      = 3'd6,
		SM_EQ      = 3'd7
	} mode_t;

	typedef enum logic [4:0] {
		TK_IDENT  = 5'd0,
		TK_NUMBER = 5'd1,
		TK_STRING = 5'd2,
		TK_PRINT  = 5'd3,
		TK_IF     = 5'd4,
		TK_ELSE   = 5'd5,
		TK_PLUS   = 5'd6,
		TK_MINUS  = 5'd7,
		TK_STAR   = 5'd8,
		TK_SLASH  = 5'd9,
		TK_EQEQ   = 5'd10,
		TK_NE     = 5'd11,
		TK_GT     = 5'd12,
		TK_GE     = 5'd13,
		TK_LT     = 5'd14,
		TK_LE     = 5'd15,
		TK_EQ     = 5'd16,
		TK_LPAREN = 5'd17,
		TK_RPAREN = 5'd18,
		TK_COMMA  = 5'd19,
		TK_EOF    = 5'd20,
		TK_INDENT = 5'd21,
		TK_EOL    = 5'd22
	} tok_kind_t;

	typedef struct packed {
		logic [4:0]       kind;
		logic [VAL_W-1:0] value;
		logic             ovf;
		logic [OUT_W-1:0] line;
		logic [OUT_W-1:0] start;
		logic [OUT_W-1:0] len;
		logic             last;
	} tok_t;

	typedef struct packed {
		logic two;
		tok_t tok0;
		tok_t tok1;
	} qent_t;

	function automatic logic [OUT_W-1:0] cnt_to_out(input logic [CNT_W-1:0] x);
		logic [CNT_W+OUT_W-1:0] w;
		w = {{OUT_W{1'b0}}, x};
		return w[OUT_W-1:0];
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

endpackage

// ----- rtl/stt_front.sv -----
`timescale 1ns / 1ps
// Scanner front end: takes one byte beat, tracks scan state, builds token entries.
module stt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic          opcode,
	input  logic [7:0]    char_byte,
	output logic          push,
	output stt_pkg::qent_t entry
);
	import stt_pkg::*;

	mode_t             mode_q, mode_d;
	logic [CNT_W-1:0]  line_q, line_d;
	logic [CNT_W-1:0]  pos_q, pos_d;
	logic [CNT_W-1:0]  tstart_q, tstart_d;
	logic [VAL_W-1:0]  acc_q, acc_d;
	logic              ovf_q, ovf_d;
	logic [NAME_W-1:0] name_q, name_d;
	logic [2:0]        nlen_q, nlen_d;

	logic       is_end, dig, alnum;
	logic       do_idle, do_flush;
	logic       id_emit, id_start, id_line;
	logic [4:0] id_kind;
	mode_t      id_mode;

	logic [34:0]       acc_ext, acc_next;
	logic [NAME_W-1:0] name_ins;
	logic [4:0]        ident_kind;
	logic [CNT_W-1:0]  span, span1;

	logic a_v, b_v;
	tok_t a_tok, b_tok;

	assign is_end = (opcode == OP_END);
	assign dig    = is_digit(char_byte);
	assign alnum  = dig || is_alpha(char_byte);
	assign span   = pos_q - tstart_q;
	assign span1  = pos_q - tstart_q + {{(CNT_W-1){1'b0}}, 1'b1};

	assign acc_ext  = {4'd0, acc_q};
	assign acc_next = (acc_ext << 3) + (acc_ext << 1) + {31'd0, char_byte[3:0]};
	assign name_ins = {{(NAME_W-8){1'b0}}, char_byte} << {nlen_q, 3'b000};

	always_comb begin
		if (nlen_q == 3'd5 && name_q == KW_PRINT) begin
			ident_kind = TK_PRINT;
		end else if (nlen_q == 3'd2 && name_q == KW_IF) begin
			ident_kind = TK_IF;
		end else if (nlen_q == 3'd4 && name_q == KW_ELSE) begin
			ident_kind = TK_ELSE;
		end else begin
			ident_kind = TK_IDENT;
		end
	end

	// classify the byte as seen from idle, and decide flush and rescan
	always_comb begin
		id_emit  = 1'b0;
		id_start = 1'b0;
		id_line  = 1'b0;
		id_kind  = TK_IDENT;
		id_mode  = SM_IDLE;
		case (char_byte)
			CH_PLUS: begin id_emit = 1'b1; id_kind = TK_PLUS; end
			CH_MINUS: begin id_emit = 1'b1; id_kind = TK_MINUS; end
			CH_STAR: begin id_emit = 1'b1; id_kind = TK_STAR; end
			CH_SLASH: begin id_emit = 1'b1; id_kind = TK_SLASH; end
			CH_LPAREN: begin id_emit = 1'b1; id_kind = TK_LPAREN; end
			CH_RPAREN: begin id_emit = 1'b1; id_kind = TK_RPAREN; end
			CH_COMMA: begin id_emit = 1'b1; id_kind = TK_COMMA; end
			CH_TAB: begin id_emit = 1'b1; id_kind = TK_INDENT; end
			CH_LF: begin id_emit = 1'b1; id_kind = TK_EOL; id_line = 1'b1; end
			CH_HASH: id_mode = SM_COMMENT;
			CH_QUOTE: begin id_mode = SM_STRING; id_start = 1'b1; end
			CH_LT: begin id_mode = SM_LT; id_start = 1'b1; end
			CH_GT: begin id_mode = SM_GT; id_start = 1'b1; end
			CH_EQ: begin id_mode = SM_EQ; id_start = 1'b1; end
			default: begin
				if (dig) begin
					id_mode  = SM_NUMBER;
					id_start = 1'b1;
				end else if (alnum) begin
					id_mode  = SM_IDENT;
					id_start = 1'b1;
				end
			end
		endcase

		do_flush = is_end;
		do_idle  = 1'b0;
		if (!is_end) begin
			case (mode_q)
				SM_IDLE: do_idle = 1'b1;
				SM_COMMENT: do_idle = (char_byte == CH_LF);
				SM_STRING: do_idle = 1'b0;
				SM_NUMBER: begin do_flush = !dig; do_idle = !dig; end
				SM_IDENT: begin do_flush = !alnum; do_idle = !alnum; end
				SM_LT, SM_GT, SM_EQ: begin
					do_flush = (char_byte != CH_EQ);
					do_idle  = (char_byte != CH_EQ);
				end
				default: do_idle = 1'b0;
			endcase
		end
	end

	// next state
	always_comb begin
		mode_d   = mode_q;
		line_d   = line_q;
		pos_d    = pos_q;
		tstart_d = tstart_q;
		acc_d    = acc_q;
		ovf_d    = ovf_q;
		name_d   = name_q;
		nlen_d   = nlen_q;
		if (accept) begin
			if (is_end) begin
				mode_d   = SM_IDLE;
				line_d   = {{(CNT_W-1){1'b0}}, 1'b1};
				pos_d    = '0;
				tstart_d = '0;
				acc_d    = '0;
				ovf_d    = 1'b0;
				name_d   = '0;
				nlen_d   = '0;
			end else begin
				pos_d = pos_q + {{(CNT_W-1){1'b0}}, 1'b1};
				case (mode_q)
					SM_STRING: begin
						if (char_byte == CH_QUOTE) begin
							mode_d = SM_IDLE;
						end else if (char_byte == CH_LF) begin
							line_d = line_q + {{(CNT_W-1){1'b0}}, 1'b1};
						end
					end
					SM_NUMBER: begin
						if (dig) begin
							if (acc_next > {4'd0, VAL_MAX}) begin
								acc_d = VAL_MAX;
								ovf_d = 1'b1;
							end else begin
								acc_d = acc_next[VAL_W-1:0];
							end
						end
					end
					SM_IDENT: begin
						if (alnum) begin
							if (nlen_q < 3'd5) name_d = name_q | name_ins;
							if (nlen_q < 3'd6) nlen_d = nlen_q + 3'd1;
						end
					end
					SM_LT, SM_GT, SM_EQ: begin
						if (char_byte == CH_EQ) mode_d = SM_IDLE;
					end
					default: mode_d = mode_q;
				endcase
				if (do_idle) begin
					mode_d = id_mode;
					if (id_start) tstart_d = pos_q;
					if (id_line) line_d = line_q + {{(CNT_W-1){1'b0}}, 1'b1};
					if (id_mode == SM_NUMBER) begin
						acc_d = {{(VAL_W-4){1'b0}}, char_byte[3:0]};
						ovf_d = 1'b0;
					end
					if (id_mode == SM_IDENT) begin
						name_d = {{(NAME_W-8){1'b0}}, char_byte};
						nlen_d = 3'd1;
					end
				end
			end
		end
	end

	// tokens produced by this beat
	always_comb begin
		a_v   = 1'b0;
		b_v   = 1'b0;
		a_tok = '0;
		b_tok = '0;
		a_tok.line  = cnt_to_out(line_q);
		a_tok.start = cnt_to_out(tstart_q);
		b_tok.line  = cnt_to_out(line_q);
		b_tok.start = cnt_to_out(pos_q);
		b_tok.last  = 1'b1;

		if (do_flush) begin
			case (mode_q)
				SM_NUMBER: begin
					a_v         = 1'b1;
					a_tok.kind  = TK_NUMBER;
					a_tok.value = acc_q;
					a_tok.ovf   = ovf_q;
					a_tok.len   = cnt_to_out(span);
				end
				SM_IDENT: begin
					a_v        = 1'b1;
					a_tok.kind = ident_kind;
					a_tok.len  = cnt_to_out(span);
				end
				SM_LT: begin a_v = 1'b1; a_tok.kind = TK_LT; a_tok.len = OUT_W'(1); end
				SM_GT: begin a_v = 1'b1; a_tok.kind = TK_GT; a_tok.len = OUT_W'(1); end
				SM_EQ: begin a_v = 1'b1; a_tok.kind = TK_EQ; a_tok.len = OUT_W'(1); end
				default: a_v = 1'b0;
			endcase
		end else if (!is_end && mode_q == SM_STRING && char_byte == CH_QUOTE) begin
			a_v        = 1'b1;
			a_tok.kind = TK_STRING;
			a_tok.len  = cnt_to_out(span1);
		end else if (!is_end && char_byte == CH_EQ &&
				(mode_q == SM_LT || mode_q == SM_GT || mode_q == SM_EQ)) begin
			a_v       = 1'b1;
			a_tok.len = OUT_W'(2);
			case (mode_q)
				SM_LT: a_tok.kind = TK_LE;
				SM_GT: a_tok.kind = TK_GE;
				default: a_tok.kind = TK_EQEQ;
			endcase
		end

		if (is_end) begin
			b_v        = 1'b1;
			b_tok.kind = TK_EOF;
		end else if (do_idle && id_emit) begin
			b_v        = 1'b1;
			b_tok.kind = id_kind;
			b_tok.len  = OUT_W'(1);
		end

		a_tok.last = !b_v;
	end

	assign push      = accept && (a_v || b_v);
	assign entry.two = a_v && b_v;
	assign entry.tok0 = a_v ? a_tok : b_tok;
	assign entry.tok1 = b_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= SM_IDLE;
			line_q   <= {{(CNT_W-1){1'b0}}, 1'b1};
			pos_q    <= '0;
			tstart_q <= '0;
			acc_q    <= '0;
			ovf_q    <= 1'b0;
			name_q   <= '0;
			nlen_q   <= '0;
		end else begin
			mode_q   <= mode_d;
			line_q   <= line_d;
			pos_q    <= pos_d;
			tstart_q <= tstart_d;
			acc_q    <= acc_d;
			ovf_q    <= ovf_d;
			name_q   <= name_d;
			nlen_q   <= nlen_d;
		end
	end

endmodule

// ----- rtl/stt_queue.sv -----
`timescale 1ns / 1ps
// Short entry queue between the scanner front end and the token back end.
module stt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  stt_pkg::qent_t wdata,
	input  logic           pop,
	output stt_pkg::qent_t rdata,
	output logic           nonempty,
	output logic           full
);
	import stt_pkg::*;

	qent_t           mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wptr_q, rptr_q;
	logic [Q_CW-1:0] cnt_q;

	assign rdata    = mem_q[rptr_q];
	assign nonempty = (cnt_q != '0);
	assign full     = (cnt_q == Q_CW'(Q_DEPTH));

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wptr_q + Q_AW'(1);
			if (pop) rptr_q <= (rptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rptr_q + Q_AW'(1);
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + Q_CW'(1);
				2'b01: cnt_q <= cnt_q - Q_CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/stt_back.sv -----
`timescale 1ns / 1ps
// Token back end: splits queue entries into single token beats behind an output register.
module stt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  stt_pkg::qent_t head,
	input  logic           nonempty,
	output logic           pop,
	input  logic           stall,
	output logic           valid,
	output stt_pkg::tok_t  tok
);
	import stt_pkg::*;

	logic load;
	logic half_q;
	logic valid_q;
	tok_t tok_q;

	assign load  = nonempty && (!valid_q || !stall);
	assign pop   = load && (!head.two || half_q);
	assign valid = valid_q;
	assign tok   = tok_q;

	always_ff @(posedge clk) begin
		if (load) tok_q <= half_q ? head.tok1 : head.tok0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				half_q  <= head.two && !half_q;
			end else if (!stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/source_text_tokenizer.sv -----
`timescale 1ns / 1ps
// Source text tokenizer top level: scanner front end, entry queue, token back end.
//
// Input channel (src_valid / src_stall): one beat per source byte with
// opcode = 0, then a beat with opcode = 1 to mark end of source. A beat is
// taken when src_valid is high and src_stall low; one beat per cycle is
// taken while the entry queue has room.
// Output channel (tok_valid / tok_stall): one beat per token, carrying type,
// value, overflow flag, line, start offset, length and last_in_run, which
// marks the final token caused by one input beat. A byte gives zero, one or
// two tokens; end of source flushes any pending token, then gives end of file.
// A token passes through the entry queue, then the output register.
// One input beat per cycle while the queue has room, one token per cycle while
// tok_stall is low; the back end splits a two-token entry into two token beats.
// The front and back ends meet at a four-entry queue; src_stall rises only
// when that queue is full, so a stalled receiver backs up the queue and then
// the source. A stalled token beat holds its payload.
// Reset clears the scan state (line 1, offset 0), empties the queue and drops
// any token not yet taken. End of source also rewinds the scan state.
module source_text_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic        opcode,
	input  logic [7:0]  char_byte,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [4:0]  token_type,
	output logic [30:0] number_value,
	output logic        number_overflow,
	output logic [23:0] line_number,
	output logic [23:0] start_offset,
	output logic [23:0] token_length,
	output logic        last_in_run
);
	import stt_pkg::*;

	logic  accept, push, pop, nonempty, full;
	qent_t wentry, head;
	tok_t  tok;

	assign src_stall = full;
	assign accept    = src_valid && !full;

	stt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.opcode    (opcode),
		.char_byte (char_byte),
		.push      (push),
		.entry     (wentry)
	);

	stt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (wentry),
		.pop      (pop),
		.rdata    (head),
		.nonempty (nonempty),
		.full     (full)
	);

	stt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.nonempty (nonempty),
		.pop      (pop),
		.stall    (tok_stall),
		.valid    (tok_valid),
		.tok      (tok)
	);

	assign token_type      = tok.kind;
	assign number_value    = tok.value;
	assign number_overflow = tok.ovf;
	assign line_number     = tok.line;
	assign start_offset    = tok.start;
	assign token_length    = tok.len;
	assign last_in_run     = tok.last;

endmodule

// ----- verif/source_text_tokenizer_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the source text tokenizer: directed table, random programs, token predictor.
module source_text_tokenizer_test;
	import stt_pkg::*;

	typedef struct {
		logic       op;
		logic [7:0] ch;
	} src_beat_t;

	typedef struct {
		logic             op;
		logic [7:0]       ch;
		bit               pin;
		tok_kind_t        kind;
		logic [OUT_W-1:0] line;
		logic [OUT_W-1:0] start;
		logic [OUT_W-1:0] len;
	} dir_row_t;

	localparam int DIR_ROWS = 34;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        src_valid = 1'b0;
	logic        src_stall;
	logic        opcode = OP_BYTE;
	logic [7:0]  char_byte = 8'h00;
	logic        tok_valid;
	logic        tok_stall = 1'b0;
	logic [4:0]  token_type;
	logic [30:0] number_value;
	logic        number_overflow;
	logic [23:0] line_number;
	logic [23:0] start_offset;
	logic [23:0] token_length;
	logic        last_in_run;

	// scanner copy
	mode_t              scan_mode;
	logic [CNT_W-1:0]   line_cnt;
	logic [CNT_W-1:0]   byte_pos;
	logic [CNT_W-1:0]   tok_begin;
	logic [VAL_W-1:0]   num_acc;
	logic               num_ovf;
	logic [NAME_W-1:0]  name_buf;
	logic [2:0]         name_len;

	tok_t      beat_tokens[$];
	tok_t      pending_tokens[$];
	src_beat_t program_q[$];
	int        errors = 0;
	bit        src_calm = 1'b0;
	bit        rx_calm = 1'b0;

	string word_list [8] = '{"print", "if", "else", "prin", "printx", "iff", "els", "elsex"};
	logic [7:0] punct_chars [10] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN,
		CH_RPAREN, CH_COMMA, CH_LT, CH_GT, CH_EQ};
	logic [7:0] blank_chars [4] = '{" ", CH_TAB, CH_LF, 8'h0D};

	dir_row_t dir_tab [DIR_ROWS] = '{
		'{OP_END,  8'h00,     1, TK_EOF,    1, 0, 0},
		'{OP_BYTE, CH_PLUS,   1, TK_PLUS,   1, 0, 1},
		'{OP_BYTE, CH_TAB,    1, TK_INDENT, 1, 1, 1},
		'{OP_BYTE, CH_LF,     1, TK_EOL,    1, 2, 1},
		'{OP_BYTE, "i",       0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, "f",       0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, CH_LPAREN, 0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, CH_LT,     0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, CH_EQ,     0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, CH_GT,     0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, "9",       0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, 8'hFF,     0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, CH_EQ,     0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, CH_EQ,     0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, CH_EQ,     0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, CH_RPAREN, 0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, CH_QUOTE,  0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, CH_LF,     0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, CH_QUOTE,  0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, CH_HASH,   0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, CH_STAR,   0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, CH_LF,     0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, "e",       0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, "l",       0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, "s",       0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, "e",       0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, CH_COMMA,  0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, CH_SLASH,  0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, CH_GT,     0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, CH_EQ,     0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, 8'h00,     0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, CH_QUOTE,  0, TK_IDENT,  0, 0, 0},
		'{OP_BYTE, "x",       0, TK_IDENT,  0, 0, 0},
		'{OP_END,  8'hA5,     0, TK_IDENT,  0, 0, 0}
	};

	source_text_tokenizer u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.src_valid       (src_valid),
		.src_stall       (src_stall),
		.opcode          (opcode),
		.char_byte       (char_byte),
		.tok_valid       (tok_valid),
		.tok_stall       (tok_stall),
		.token_type      (token_type),
		.number_value    (number_value),
		.number_overflow (number_overflow),
		.line_number     (line_number),
		.start_offset    (start_offset),
		.token_length    (token_length),
		.last_in_run     (last_in_run)
	);

	always #5 clk = ~clk;

	function automatic bit digit_char(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit letter_char(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic void rewind_scan();
		scan_mode = SM_IDLE;
		line_cnt  = 1;
		byte_pos  = 0;
		tok_begin = 0;
		num_acc   = 0;
		num_ovf   = 1'b0;
		name_buf  = 0;
		name_len  = 0;
	endfunction

	function automatic void add_token(input tok_kind_t k, input logic [VAL_W-1:0] v,
			input logic o, input logic [CNT_W-1:0] s, input logic [CNT_W-1:0] l);
		tok_t t;
		t.kind  = k;
		t.value = v;
		t.ovf   = o;
		t.line  = line_cnt;
		t.start = s;
		t.len   = l;
		t.last  = 1'b0;
		beat_tokens = {beat_tokens, t};
	endfunction

	function automatic void scan_fresh(input logic [7:0] c, input logic [CNT_W-1:0] pos);
		scan_mode = SM_IDLE;
		case (c)
			CH_PLUS:   add_token(TK_PLUS, 0, 0, pos, 1);
			CH_MINUS:  add_token(TK_MINUS, 0, 0, pos, 1);
			CH_STAR:   add_token(TK_STAR, 0, 0, pos, 1);
			CH_SLASH:  add_token(TK_SLASH, 0, 0, pos, 1);
			CH_LPAREN: add_token(TK_LPAREN, 0, 0, pos, 1);
			CH_RPAREN: add_token(TK_RPAREN, 0, 0, pos, 1);
			CH_COMMA:  add_token(TK_COMMA, 0, 0, pos, 1);
			CH_TAB:    add_token(TK_INDENT, 0, 0, pos, 1);
			CH_LF: begin
				add_token(TK_EOL, 0, 0, pos, 1);
				line_cnt = line_cnt + 1'b1;
			end
			CH_HASH:  scan_mode = SM_COMMENT;
			CH_QUOTE: begin
				scan_mode = SM_STRING;
				tok_begin = pos;
			end
			CH_LT: begin
				scan_mode = SM_LT;
				tok_begin = pos;
			end
			CH_GT: begin
				scan_mode = SM_GT;
				tok_begin = pos;
			end
			CH_EQ: begin
				scan_mode = SM_EQ;
				tok_begin = pos;
			end
			default: begin
				if (digit_char(c)) begin
					scan_mode = SM_NUMBER;
					tok_begin = pos;
					num_acc   = c[3:0];
					num_ovf   = 1'b0;
				end else if (letter_char(c)) begin
					scan_mode = SM_IDENT;
					tok_begin = pos;
					name_buf  = {32'd0, c};
					name_len  = 1;
				end
			end
		endcase
	endfunction

	function automatic void flush_pending(input logic [CNT_W-1:0] pos);
		tok_kind_t k;
		case (scan_mode)
			SM_NUMBER: add_token(TK_NUMBER, num_acc, num_ovf, tok_begin, pos - tok_begin);
			SM_IDENT: begin
				k = TK_IDENT;
				if (name_len == 5 && name_buf == KW_PRINT)
					k = TK_PRINT;
				else if (name_len == 2 && name_buf == KW_IF)
					k = TK_IF;
				else if (name_len == 4 && name_buf == KW_ELSE)
					k = TK_ELSE;
				add_token(k, 0, 0, tok_begin, pos - tok_begin);
			end
			SM_LT: add_token(TK_LT, 0, 0, tok_begin, 1);
			SM_GT: add_token(TK_GT, 0, 0, tok_begin, 1);
			SM_EQ: add_token(TK_EQ, 0, 0, tok_begin, 1);
			default: ;
		endcase
		scan_mode = SM_IDLE;
	endfunction

	function automatic void predict_tokens(input logic op, input logic [7:0] c);
		logic [CNT_W-1:0] pos;
		logic [VAL_W+3:0] nv;
		beat_tokens.delete();
		pos = byte_pos;
		if (op == OP_END) begin
			flush_pending(pos);
			add_token(TK_EOF, 0, 0, pos, 0);
			rewind_scan();
		end else begin
			case (scan_mode)
				SM_COMMENT: begin
					if (c == CH_LF)
						scan_fresh(c, pos);
				end
				SM_STRING: begin
					if (c == CH_QUOTE) begin
						add_token(TK_STRING, 0, 0, tok_begin, pos - tok_begin + 1'b1);
						scan_mode = SM_IDLE;
					end else if (c == CH_LF) begin
						line_cnt = line_cnt + 1'b1;
					end
				end
				SM_NUMBER: begin
					if (digit_char(c)) begin
						nv = {4'd0, num_acc} * 35'd10 + c[3:0];
						if (nv > {4'd0, VAL_MAX}) begin
							nv      = {4'd0, VAL_MAX};
							num_ovf = 1'b1;
						end
						num_acc = nv[VAL_W-1:0];
					end else begin
						flush_pending(pos);
						scan_fresh(c, pos);
					end
				end
				SM_IDENT: begin
					if (digit_char(c) || letter_char(c)) begin
						if (name_len < 5)
							name_buf[8*name_len +: 8] = c;
						if (name_len < 6)
							name_len = name_len + 1'b1;
					end else begin
						flush_pending(pos);
						scan_fresh(c, pos);
					end
				end
				SM_LT, SM_GT, SM_EQ: begin
					if (c == CH_EQ) begin
						add_token(scan_mode == SM_LT ? TK_LE : (scan_mode == SM_GT ? TK_GE : TK_EQEQ),
							0, 0, tok_begin, 2);
						scan_mode = SM_IDLE;
					end else begin
						flush_pending(pos);
						scan_fresh(c, pos);
					end
				end
				default: scan_fresh(c, pos);
			endcase
			byte_pos = pos + 1'b1;
		end
		if (beat_tokens.size() > 0)
			beat_tokens[beat_tokens.size()-1].last = 1'b1;
	endfunction

	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 13);
	endfunction

	function automatic void add_char(input logic op, input logic [7:0] c);
		src_beat_t b;
		b.op = op;
		b.ch = c;
		program_q = {program_q, b};
	endfunction

	function automatic logic [7:0] pick_letter();
		return $urandom_range(0, 1) ? $urandom_range("a", "z") : $urandom_range("A", "Z");
	endfunction

	// well-formed fragments with random content, plus some noise
	function automatic void build_program();
		int frags;
		int n;
		string w;
		logic [7:0] c;
		frags = $urandom_range(1, 24);
		for (int f = 0; f < frags; f++) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					if ($urandom_range(0, 2) == 0) begin
						w = word_list[$urandom_range(0, 7)];
						for (int i = 0; i < w.len(); i++)
							add_char(OP_BYTE, w[i]);
					end else begin
						add_char(OP_BYTE, pick_letter());
						n = $urandom_range(0, 7);
						for (int i = 0; i < n; i++)
							add_char(OP_BYTE, $urandom_range(0, 2) == 0 ?
								$urandom_range("0", "9") : pick_letter());
					end
				end
				2, 3: begin
					n = $urandom_range(0, 3) == 0 ? $urandom_range(10, 13) : $urandom_range(1, 4);
					for (int i = 0; i < n; i++)
						add_char(OP_BYTE, $urandom_range("0", "9"));
				end
				4: begin
					add_char(OP_BYTE, CH_QUOTE);
					n = $urandom_range(0, 6);
					for (int i = 0; i < n; i++) begin
						c = $urandom_range(0, 3) == 0 ? CH_LF : $urandom_range(0, 255);
						add_char(OP_BYTE, c == CH_QUOTE ? "q" : c);
					end
					if ($urandom_range(0, 9) != 0)
						add_char(OP_BYTE, CH_QUOTE);
				end
				5: begin
					add_char(OP_BYTE, CH_HASH);
					n = $urandom_range(0, 5);
					for (int i = 0; i < n; i++) begin
						c = $urandom_range(0, 255);
						add_char(OP_BYTE, c == CH_LF ? CH_HASH : c);
					end
					if ($urandom_range(0, 4) != 0)
						add_char(OP_BYTE, CH_LF);
				end
				6, 7: begin
					c = punct_chars[$urandom_range(0, 9)];
					add_char(OP_BYTE, c);
					if ((c == CH_LT || c == CH_GT || c == CH_EQ) && $urandom_range(0, 1))
						add_char(OP_BYTE, CH_EQ);
				end
				8: add_char(OP_BYTE, blank_chars[$urandom_range(0, 3)]);
				default: add_char(OP_BYTE, $urandom_range(0, 255));
			endcase
			if ($urandom_range(0, 2) == 0)
				add_char(OP_BYTE, " ");
		end
		add_char(OP_END, $urandom_range(0, 255));
	endfunction

	task automatic send_beat(input logic op, input logic [7:0] c, input bit pin,
			input tok_t pinned);
		int gap;
		gap = draw_gap(src_calm);
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		opcode    <= op;
		char_byte <= c;
		do @(posedge clk); while (src_stall);
		predict_tokens(op, c);
		if (pin) begin
			beat_tokens.delete();
			beat_tokens = {beat_tokens, pinned};
		end
		foreach (beat_tokens[i])
			pending_tokens = {pending_tokens, beat_tokens[i]};
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	initial begin
		tok_t pinned;
		rewind_scan();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIR_ROWS; i++) begin
			pinned.kind  = dir_tab[i].kind;
			pinned.value = 0;
			pinned.ovf   = 1'b0;
			pinned.line  = dir_tab[i].line;
			pinned.start = dir_tab[i].start;
			pinned.len   = dir_tab[i].len;
			pinned.last  = 1'b1;
			send_beat(dir_tab[i].op, dir_tab[i].ch, dir_tab[i].pin, pinned);
		end
		while (program_q.size() < 600)
			build_program();
		foreach (program_q[i])
			send_beat(program_q[i].op, program_q[i].ch, 1'b0, pinned);
		src_valid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("source_text_tokenizer_test passed");
		else
			$display("source_text_tokenizer_test failed");
		$finish;
	end

	initial begin
		int gap;
		forever begin
			gap = draw_gap(rx_calm);
			if (gap > 0) begin
				tok_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				tok_stall <= 1'b0;
			end
			do @(posedge clk); while (!(tok_valid && !tok_stall));
		end
	end

	always @(posedge clk) begin
		tok_t want;
		if (arst_n && tok_valid && !tok_stall) begin
			if (pending_tokens.size() == 0) begin
				$error("token beat with nothing expected: type %0d at offset %0d",
					token_type, start_offset);
				errors++;
			end else begin
				want = pending_tokens.pop_front();
				check_field("token_type", want.kind, token_type);
				check_field("number_value", want.value, number_value);
				check_field("number_overflow", want.ovf, number_overflow);
				check_field("line_number", want.line, line_number);
				check_field("start_offset", want.start, start_offset);
				check_field("token_length", want.len, token_length);
				check_field("last_in_run", want.last, last_in_run);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("source_text_tokenizer_test failed");
		$finish;
	end

endmodule
